// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared operation codes and status type for the circular deque.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_POP_FRONT  = 2'd1,
      OP_PUSH_FRONT = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   // status of one finished operation, as registered for the response
   typedef struct packed {
      logic valid;
      logic ok;
      logic pop;
      logic empty;
      logic full;
   } status_type;

endpackage

// ===== src/circular_deque_top.sv =====
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue over a ring of DEPTH slots, holding up to DEPTH-1 items.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle (busy stays low) and its response
// appears on the rsp_ ports in the cycle after the transfer, flagged by
// rsp_valid for a single cycle; the receiver cannot stall. Status and the
// slot memory read are registered; a pop issued right after a push to the
// same slot sees the new data because the write lands at the edge that
// accepts the push. Refused operations return ok low and zero data.
module circular_deque_top #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_data_in,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_data_out,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full
);

   localparam int AW = $clog2(DEPTH);

   logic                             accept;
   logic                             wr_en, rd_en;
   logic [AW-1:0]                    wr_addr, rd_addr;
   logic signed [dq_pkg::DATA_W-1:0] wr_data, rd_data;
   dq_pkg::status_type               status;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   dq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (dq_pkg::op_type'(req_op)),
      .data_in (req_data_in),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (status)
   );

   dq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid    = status.valid;
   assign rsp_ok       = status.ok;
   assign rsp_data_out = (status.ok && status.pop) ? rd_data : '0;
   assign rsp_is_empty = status.empty;
   assign rsp_is_full  = status.full;

endmodule

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [dq_pkg::DATA_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output logic signed [dq_pkg::DATA_W-1:0] rd_data
);

   logic signed [dq_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [dq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointers, full and empty decode, slot access and response status.
// ----------------------------------------------------------------------------
module dq_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  dq_pkg::op_type                   op,
   input  logic signed [dq_pkg::DATA_W-1:0] data_in,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic signed [dq_pkg::DATA_W-1:0] wr_data,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_addr,
   output dq_pkg::status_type               status
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0]      front_ff, front_in;
   logic [AW-1:0]      rear_ff, rear_in;
   dq_pkg::status_type status_ff, status_in;

   logic [AW-1:0] front_next, front_prev, rear_next, rear_prev;
   logic          empty_now, full_now, ok, is_pop;

   assign front_next = (front_ff == LAST) ? '0 : front_ff + AW'(1);
   assign front_prev = (front_ff == '0) ? LAST : front_ff - AW'(1);
   assign rear_next  = (rear_ff == LAST) ? '0 : rear_ff + AW'(1);
   assign rear_prev  = (rear_ff == '0) ? LAST : rear_ff - AW'(1);

   assign empty_now = (front_ff == rear_ff);
   assign full_now  = (rear_next == front_ff);

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      wr_en    = 1'b0;
      wr_addr  = rear_next;
      rd_en    = 1'b0;
      rd_addr  = front_next;
      ok       = 1'b0;
      is_pop   = 1'b0;
      case (op)
         dq_pkg::OP_PUSH_BACK: begin
            ok       = !full_now;
            wr_addr  = rear_next;
            wr_en    = accept && ok;
            if (wr_en) rear_in = rear_next;
         end
         dq_pkg::OP_POP_FRONT: begin
            ok       = !empty_now;
            is_pop   = 1'b1;
            rd_addr  = front_next;
            rd_en    = accept && ok;
            if (rd_en) front_in = front_next;
         end
         dq_pkg::OP_PUSH_FRONT: begin
            ok       = !full_now;
            wr_addr  = front_ff;
            wr_en    = accept && ok;
            if (wr_en) front_in = front_prev;
         end
         default: begin
            ok       = !empty_now;
            is_pop   = 1'b1;
            rd_addr  = rear_ff;
            rd_en    = accept && ok;
            if (rd_en) rear_in = rear_prev;
         end
      endcase
   end

   assign wr_data = data_in;

   // flags after the step, from the updated pointers
   always_comb begin
      status_in.valid = accept;
      status_in.ok    = ok;
      status_in.pop   = is_pop;
      status_in.empty = (front_in == rear_in);
      status_in.full  = (((rear_in == LAST) ? '0 : rear_in + AW'(1)) == front_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff        <= '0;
         rear_ff         <= '0;
         status_ff.valid <= 1'b0;
      end else begin
         front_ff        <= front_in;
         rear_ff         <= rear_in;
         status_ff.valid <= status_in.valid;
      end
      status_ff.ok    <= status_in.ok;
      status_ff.pop   <= status_in.pop;
      status_ff.empty <= status_in.empty;
      status_ff.full  <= status_in.full;
   end

   assign status = status_ff;

endmodule

// ===== src/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on response timing and status consistency.
// ----------------------------------------------------------------------------
module dq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_ok,
   input logic signed [dq_pkg::DATA_W-1:0] rsp_data_out,
   input logic                             rsp_is_empty,
   input logic                             rsp_is_full
);

   // every transfer gets its response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("response missing after transfer");

   // no response without a transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without transfer");

   // refused operations carry zero data
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_data_out == '0))
      else $error("refused operation returned data");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("deque reported empty and full");

   // a refusal only happens at a limit, and the state is left there
   a_refused_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_is_empty || rsp_is_full))
      else $error("refused operation away from empty or full");

endmodule

bind circular_deque_top dq_checker u_dq_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_ok       (rsp_ok),
   .rsp_data_out (rsp_data_out),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full)
);
